// File: src/per_key_traffic_counter_sampler_assert.svh
// assertion macros for the per-key traffic counter
`ifndef PER_KEY_TRAFFIC_COUNTER_SAMPLER_ASSERT_SVH
`define PER_KEY_TRAFFIC_COUNTER_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PKTC_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`define PKTC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define PKTC_ASSERT_NEVER(label, clk, rst, cond)
`define PKTC_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: src/pktc_pkg.sv
`default_nettype none
package pktc_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int SAMPLE_PERIOD = 10;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int PH_W = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
  localparam int PH_INIT = 1 % SAMPLE_PERIOD;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [5:0] IP_END_BYTES = 6'd34;
  localparam logic [5:0] TCP_END_BYTES = 6'd54;
  localparam logic [5:0] UDP_END_BYTES = 6'd42;

  typedef struct packed {
    logic        ok;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_info_t;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic [63:0]     bytes;
    logic [63:0]     packets;
  } count_word_t;

  typedef struct packed {
    logic        used;
    logic [31:0] key;
  } key_word_t;
endpackage
`default_nettype wire

// File: src/pktc_parse.sv
`default_nettype none
module pktc_parse (
  input  wire logic [5:0]       captured_bytes,
  input  wire logic [15:0]      ether_type,
  input  wire logic [7:0]       ip_protocol,
  input  wire logic [31:0]      source_addr,
  input  wire logic [31:0]      dest_addr,
  input  wire logic [15:0]      l4_source_port,
  input  wire logic [15:0]      l4_dest_port,
  output pktc_pkg::hdr_info_t   info
);
  logic ports_ok;

  // ipv4 with full eth and ip headers
  assign info.ok = (ether_type == pktc_pkg::ETHERTYPE_IPV4) &&
                   (captured_bytes >= pktc_pkg::IP_END_BYTES);
  assign ports_ok = ((ip_protocol == pktc_pkg::PROTO_TCP) &&
                     (captured_bytes >= pktc_pkg::TCP_END_BYTES)) ||
                    ((ip_protocol == pktc_pkg::PROTO_UDP) &&
                     (captured_bytes >= pktc_pkg::UDP_END_BYTES));
  assign info.protocol = ip_protocol;
  assign info.src_addr = source_addr;
  assign info.dst_addr = dest_addr;
  assign info.sport = ports_ok ? l4_source_port : 16'd0;
  assign info.dport = ports_ok ? l4_dest_port : 16'd0;
endmodule
`default_nettype wire

// File: src/per_key_traffic_counter_sampler.sv
`default_nettype none
// sequence: the result is registered after S_LOOK, S_EVAL and S_DONE when the key
//   sits in its home slot; each further open-addressed probe repeats LOOK and EVAL
// items: one at a time, taken in S_IDLE only; read-modify-write of the table
//   memories (one read port, one write port, read data registered)
// reset: control state clears, then a pass over all TABLE_ENTRIES slots clears
//   the slot-used flags; no input is taken during that pass
module per_key_traffic_counter_sampler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] group_key,
  input  wire logic [31:0] proc_id,
  input  wire logic [31:0] user_id,
  input  wire logic [15:0] packet_length,
  input  wire logic [5:0]  captured_bytes,
  input  wire logic [15:0] ether_type,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [31:0] source_addr,
  input  wire logic [31:0] dest_addr,
  input  wire logic [15:0] l4_source_port,
  input  wire logic [15:0] l4_dest_port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             event_valid,
  output logic [31:0]      event_key,
  output logic [31:0]      event_proc,
  output logic [31:0]      event_user,
  output logic [7:0]       event_protocol,
  output logic [15:0]      event_length,
  output logic [31:0]      event_src_addr,
  output logic [31:0]      event_dst_addr,
  output logic [15:0]      event_src_port,
  output logic [15:0]      event_dst_port,
  output logic [63:0]      packets_so_far,
  output logic [63:0]      bytes_so_far
);
`include "per_key_traffic_counter_sampler_assert.svh"

  localparam int IW = pktc_pkg::IDX_W;
  localparam int CW = pktc_pkg::CNT_W;
  localparam int PW = pktc_pkg::PH_W;
  localparam int N  = pktc_pkg::TABLE_ENTRIES;

  // sequencer: clear pass, idle, issue read, evaluate read data, deliver
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // table memories: key plus used flag, and counts plus period phase
  pktc_pkg::key_word_t   key_mem [N];
  pktc_pkg::count_word_t cnt_mem [N];
  pktc_pkg::key_word_t   key_rd;
  pktc_pkg::count_word_t cnt_rd;

  logic                  key_we, cnt_we;
  logic [IW-1:0]         wr_addr;
  pktc_pkg::key_word_t   key_wr;
  pktc_pkg::count_word_t cnt_wr;

  // held item
  logic [31:0] key_q, proc_q, user_q;
  logic [15:0] len_q;
  pktc_pkg::hdr_info_t hdr_q, hdr_in;

  logic [IW-1:0] probe;       // slot under test
  logic [CW-1:0] probes;      // slots already rejected
  logic [CW-1:0] fill;        // slots in use
  logic [IW-1:0] clr_idx;

  logic [63:0] pk_res, by_res;
  logic        smp_res;

  logic          in_xfer, out_xfer, out_free;
  logic [IW-1:0] home, probe_inc;
  logic          hit, empty, wrapped;
  logic [63:0]   pk_inc, by_inc;
  logic [PW-1:0] ph_inc;

  pktc_parse u_parse (
    .captured_bytes (captured_bytes),
    .ether_type     (ether_type),
    .ip_protocol    (ip_protocol),
    .source_addr    (source_addr),
    .dest_addr      (dest_addr),
    .l4_source_port (l4_source_port),
    .l4_dest_port   (l4_dest_port),
    .info           (hdr_in)
  );

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign out_free = !out_valid || out_ready;

  // home slot: low key bits, folded to 0 past the table end
  always_comb begin
    home = group_key[IW-1:0];
    if ({1'b0, home} > CW'(N - 1)) begin
      home = '0;
    end
  end

  assign probe_inc = ({1'b0, probe} == CW'(N - 1)) ? '0 : probe + 1'b1;

  // evaluation of the slot read in the previous cycle
  assign hit     = key_rd.used && (key_rd.key == key_q);
  assign empty   = !key_rd.used;
  assign wrapped = (probes == CW'(N - 1));
  assign pk_inc  = cnt_rd.packets + 64'd1;
  assign by_inc  = cnt_rd.bytes + {48'd0, len_q};
  assign ph_inc  = ({1'b0, cnt_rd.phase} == (PW + 1)'(pktc_pkg::SAMPLE_PERIOD - 1)) ?
                   '0 : cnt_rd.phase + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if ({1'b0, clr_idx} == CW'(N - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_xfer) state_next = S_LOOK;
      S_LOOK:  state_next = S_EVAL;
      S_EVAL:  if (hit || empty || wrapped) state_next = S_DONE;
               else state_next = S_LOOK;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // write port: clear pass, or the update of a found or new entry
  always_comb begin
    key_we  = 1'b0;
    cnt_we  = 1'b0;
    wr_addr = probe;
    key_wr  = '{used: 1'b1, key: key_q};
    cnt_wr  = '{phase: PW'(pktc_pkg::PH_INIT), bytes: {48'd0, len_q}, packets: 64'd1};
    if (state == S_CLEAR) begin
      key_we  = 1'b1;
      wr_addr = clr_idx;
      key_wr  = '{used: 1'b0, key: 32'd0};
    end else if (state == S_EVAL) begin
      if (hit) begin
        cnt_we = 1'b1;
        cnt_wr = '{phase: ph_inc, bytes: by_inc, packets: pk_inc};
      end else if (empty) begin
        key_we = 1'b1;
        cnt_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_wr;
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wr;
    key_rd <= key_mem[probe];
    cnt_rd <= cnt_mem[probe];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == S_EVAL && !hit && empty) fill <= fill + 1'b1;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_xfer) out_valid <= 1'b0;
    end
  end

  // item, probe and result registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_q  <= group_key;
      proc_q <= proc_id;
      user_q <= user_id;
      len_q  <= packet_length;
      hdr_q  <= hdr_in;
      probe  <= home;
      probes <= '0;
    end
    if (state == S_EVAL) begin
      if (hit) begin
        pk_res  <= pk_inc;
        by_res  <= by_inc;
        smp_res <= (ph_inc == '0);
      end else if (empty || wrapped) begin
        // new key, stored or not: counts start over and it is sampled
        pk_res  <= 64'd1;
        by_res  <= {48'd0, len_q};
        smp_res <= 1'b1;
      end else begin
        probe  <= probe_inc;
        probes <= probes + 1'b1;
      end
    end
    if (state == S_DONE && out_free) begin
      event_valid    <= smp_res && hdr_q.ok;
      event_key      <= key_q;
      event_proc     <= proc_q;
      event_user     <= user_q;
      event_length   <= len_q;
      event_protocol <= (smp_res && hdr_q.ok) ? hdr_q.protocol : 8'd0;
      event_src_addr <= (smp_res && hdr_q.ok) ? hdr_q.src_addr : 32'd0;
      event_dst_addr <= (smp_res && hdr_q.ok) ? hdr_q.dst_addr : 32'd0;
      event_src_port <= (smp_res && hdr_q.ok) ? hdr_q.sport : 16'd0;
      event_dst_port <= (smp_res && hdr_q.ok) ? hdr_q.dport : 16'd0;
      packets_so_far <= pk_res;
      bytes_so_far   <= by_res;
    end
  end

  // never more slots in use than the table holds
  `PKTC_ASSERT_NEVER(a_fill_bound, clk, rst, fill > CW'(N))
  // an input transfer starts a table read
  `PKTC_ASSERT_NEXT(a_xfer_look, clk, rst, in_xfer, state == S_LOOK)
  // a new entry is only written while a free slot is counted
  `PKTC_ASSERT_NEVER(a_insert_room, clk, rst, key_we && state == S_EVAL && fill == CW'(N))
  // a held result is not replaced before its transfer
  `PKTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire
